// ===== rtl/pso_pkg.sv =====
// ----------------------------------------------------------------------------
// pso_pkg
// Shared types and constants of the path offset sampler.
// ----------------------------------------------------------------------------
package pso_pkg;

  localparam int unsigned FRAC = 24;

  // request kinds
  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_APPEND = 3'd1,
    REQ_REWIND = 3'd2,
    REQ_LINE   = 3'd3,
    REQ_CUBIC  = 3'd4
  } req_kind_e;

  // segment geometry handed to the evaluator
  typedef struct packed {
    logic               cubic;
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] c1_x;
    logic signed [31:0] c1_y;
    logic signed [31:0] c2_x;
    logic signed [31:0] c2_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } seg_t;

endpackage

// ===== rtl/pso_if.sv =====
// ----------------------------------------------------------------------------
// pso_if
// Request and point channels of the path offset sampler.
// ----------------------------------------------------------------------------
interface pso_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [31:0]        wanted_value;
  logic [31:0]        start_offset;
  logic [31:0]        seg_length;
  logic signed [31:0] from_x;
  logic signed [31:0] from_y;
  logic signed [31:0] c1_x;
  logic signed [31:0] c1_y;
  logic signed [31:0] c2_x;
  logic signed [31:0] c2_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;

  modport source (output valid, req_type, wanted_value, start_offset, seg_length,
                  from_x, from_y, c1_x, c1_y, c2_x, c2_y, end_x, end_y,
                  input ready);
  modport sink (input valid, req_type, wanted_value, start_offset, seg_length,
                from_x, from_y, c1_x, c1_y, c2_x, c2_y, end_x, end_y,
                output ready);
endinterface

interface pso_pnt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

// ===== rtl/pso_table.sv =====
// ----------------------------------------------------------------------------
// pso_table
// Offset table memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pso_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [31:0]   wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [31:0]   rd_data_o
);

  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== rtl/pso_div.sv =====
// ----------------------------------------------------------------------------
// pso_div
// Restoring divider for the segment parameter t, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pso_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] want_i,
  input  logic [31:0] start_offset_i,
  input  logic [31:0] seg_length_i,
  output logic        done_o,
  output logic [23:0] t_o
);
  import pso_pkg::*;

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [32:0] rem_q;
  logic [31:0] len_q;
  logic [23:0] quo_q;
  logic        done_q;
  logic [33:0] rem2;
  logic        ge;

  assign rem2 = {rem_q, 1'b0};
  assign ge   = rem2 >= {2'b00, len_q};

  // control and datapath of the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (want_i < start_offset_i || seg_length_i == '0) begin
          quo_q  <= '0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= 5'(FRAC - 1);
          rem_q  <= {1'b0, want_i - start_offset_i};
          len_q  <= seg_length_i;
          quo_q  <= '0;
        end
      end else if (busy_q) begin
        rem_q <= ge ? 33'(rem2 - {2'b00, len_q}) : rem2[32:0];
        quo_q <= {quo_q[22:0], ge};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign t_o    = quo_q;

endmodule

// ===== rtl/pso_eval.sv =====
// ----------------------------------------------------------------------------
// pso_eval
// Point evaluator, a sequencer around one shared registered multiplier.
// ----------------------------------------------------------------------------
module pso_eval (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [23:0]        t_i,
  input  pso_pkg::seg_t      seg_i,
  output logic               done_o,
  output logic signed [31:0] px_o,
  output logic signed [31:0] py_o
);
  import pso_pkg::*;

  localparam logic signed [59:0] HALF = 60'sd1 <<< (FRAC - 1);
  localparam logic signed [61:0] HALF_W = 62'sd1 <<< (FRAC - 1);
  localparam logic signed [26:0] ONE = 27'sd1 <<< FRAC;

  logic               busy_q, phase_q, done_q;
  logic [3:0]         op_q;
  logic signed [32:0] a_op;
  logic signed [26:0] b_op;
  logic signed [59:0] prod_q;
  logic signed [59:0] prod_r;
  logic signed [61:0] acc_q, acc_sum;
  logic signed [37:0] acc_r;
  logic signed [31:0] sat_v;
  logic signed [26:0] t_s, u_s, tt_q, uu_q, w0_q, w1_q, w2_q, w3_q;
  logic signed [31:0] px_q, py_q;
  logic [3:0]         last_op;

  assign t_s     = {3'b000, t_i};
  assign u_s     = ONE - t_s;
  assign prod_r  = (prod_q + HALF) >>> FRAC;
  assign acc_sum = acc_q + 62'(prod_q);
  assign acc_r   = 38'((acc_sum + HALF_W) >>> FRAC);
  assign last_op = seg_i.cubic ? 4'd12 : 4'd1;

  // saturate the rounded sum to 32 bits
  always_comb begin
    if (acc_r > 38'sd2147483647) begin
      sat_v = 32'sh7fffffff;
    end else if (acc_r < -38'sd2147483648) begin
      sat_v = 32'sh80000000;
    end else begin
      sat_v = acc_r[31:0];
    end
  end

  // operand selection per step
  always_comb begin
    a_op = '0;
    b_op = '0;
    if (!seg_i.cubic) begin
      a_op = (op_q == 4'd0) ? 33'(seg_i.end_x) - 33'(seg_i.from_x)
                            : 33'(seg_i.end_y) - 33'(seg_i.from_y);
      b_op = t_s;
    end else begin
      unique case (op_q)
        4'd0:    begin a_op = 33'(t_s);          b_op = t_s;  end
        4'd1:    begin a_op = 33'(u_s);          b_op = u_s;  end
        4'd2:    begin a_op = 33'(uu_q);         b_op = u_s;  end
        4'd3:    begin a_op = 33'(t_s) * 33'sd3; b_op = uu_q; end
        4'd4:    begin a_op = 33'(tt_q);         b_op = t_s;  end
        4'd5:    begin a_op = 33'(seg_i.from_x); b_op = w0_q; end
        4'd6:    begin a_op = 33'(seg_i.c1_x);   b_op = w1_q; end
        4'd7:    begin a_op = 33'(seg_i.c2_x);   b_op = w2_q; end
        4'd8:    begin a_op = 33'(seg_i.end_x);  b_op = w3_q; end
        4'd9:    begin a_op = 33'(seg_i.from_y); b_op = w0_q; end
        4'd10:   begin a_op = 33'(seg_i.c1_y);   b_op = w1_q; end
        4'd11:   begin a_op = 33'(seg_i.c2_y);   b_op = w2_q; end
        default: begin a_op = 33'(seg_i.end_y);  b_op = w3_q; end
      endcase
    end
  end

  // multiply on phase 0, consume on phase 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      op_q    <= '0;
      acc_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        op_q    <= '0;
        acc_q   <= '0;
      end else if (busy_q && !phase_q) begin
        prod_q  <= 60'(a_op * b_op);
        phase_q <= 1'b1;
      end else if (busy_q) begin
        phase_q <= 1'b0;
        if (!seg_i.cubic) begin
          if (op_q == 4'd0) px_q <= seg_i.from_x + prod_r[31:0];
          else              py_q <= seg_i.from_y + prod_r[31:0];
        end else begin
          unique case (op_q)
            4'd0: tt_q <= prod_r[26:0];
            4'd1: uu_q <= prod_r[26:0];
            4'd2: w0_q <= prod_r[26:0];
            4'd3: w1_q <= prod_r[26:0];
            4'd4: begin
              w3_q <= prod_r[26:0];
              w2_q <= ONE - w0_q - w1_q - prod_r[26:0];
            end
            4'd8: begin
              px_q  <= sat_v;
              acc_q <= '0;
            end
            4'd12: begin
              py_q  <= sat_v;
              acc_q <= '0;
            end
            default: acc_q <= acc_sum;
          endcase
        end
        if (op_q == last_op) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          op_q <= op_q + 4'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign px_o   = px_q;
  assign py_o   = py_q;

endmodule

// ===== rtl/path_sampler_at_offsets.sv =====
// ----------------------------------------------------------------------------
// path_sampler_at_offsets
// Samples line and cubic path segments at a table of wanted offsets.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_i, one transaction per item. Clear, append
// and rewind items update the offset table or the index and give no
// points. A line or cubic item walks the table from the index and gives one
// point on pnt_o per wanted offset below the segment end; the final point
// of the item carries last_point.
// A segment item starts with a first table lookup. Each point then passes
// through the bit serial divider, the shared multiplier sequencer and a
// lookahead read of the next table entry before it is offered on pnt_o.
// A new request is taken only once the previous item has finished.
// Reset clears the table count and the index; the table contents stay
// unknown until appended. When the receiver stalls, the point holds on
// pnt_o and the walk waits until it is taken.
// ----------------------------------------------------------------------------
module path_sampler_at_offsets #(
  parameter int unsigned MAX_OFFSETS = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pso_req_if.sink   req_i,
  pso_pnt_if.source pnt_o
);
  import pso_pkg::*;

  localparam int unsigned AW = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
  localparam int unsigned CW = $clog2(MAX_OFFSETS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_OFFSETS);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CHK, S_DIV, S_EVAL, S_LOOK, S_LCHK, S_EMIT
  } state_e;

  state_e        state_q;
  logic [CW-1:0] count_q, idx_q, idx_nx;
  logic [32:0]   seg_end_q;
  logic [31:0]   start_q, len_q, want_nx_q, rd_data, div_want;
  logic          last_q, div_start, div_done, eval_done, wr_en, qual;
  logic [23:0]   t;
  seg_t          seg_q;
  logic [AW-1:0] rd_addr;
  logic signed [31:0] px, py;

  assign idx_nx  = idx_q + CW'(1);
  assign rd_addr = (state_q == S_LOOK) ? idx_nx[AW-1:0] : idx_q[AW-1:0];
  assign wr_en   = (state_q == S_IDLE) && req_i.valid &&
                   (req_i.req_type == REQ_APPEND) && (count_q < MAX_CNT);
  assign qual    = (idx_q < count_q) && ({1'b0, rd_data} < seg_end_q);

  // divider start, first point or a following point after hand-off
  always_comb begin
    div_start = 1'b0;
    div_want  = rd_data;
    if (state_q == S_CHK && qual) begin
      div_start = 1'b1;
    end else if (state_q == S_EMIT && pnt_o.ready && !last_q) begin
      div_start = 1'b1;
      div_want  = want_nx_q;
    end
  end

  pso_table #(.DEPTH(MAX_OFFSETS), .AW(AW)) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (req_i.wanted_value),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pso_div u_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (div_start),
    .want_i         (div_want),
    .start_offset_i (start_q),
    .seg_length_i   (len_q),
    .done_o         (div_done),
    .t_o            (t)
  );

  pso_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_done),
    .t_i     (t),
    .seg_i   (seg_q),
    .done_o  (eval_done),
    .px_o    (px),
    .py_o    (py)
  );

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            unique case (req_i.req_type)
              REQ_CLEAR: begin
                count_q <= '0;
                idx_q   <= '0;
              end
              REQ_APPEND: begin
                if (count_q < MAX_CNT) count_q <= count_q + CW'(1);
              end
              REQ_REWIND: idx_q <= '0;
              REQ_LINE, REQ_CUBIC: begin
                start_q      <= req_i.start_offset;
                len_q        <= req_i.seg_length;
                seg_end_q    <= {1'b0, req_i.start_offset} + {1'b0, req_i.seg_length};
                seg_q.cubic  <= (req_i.req_type == REQ_CUBIC);
                seg_q.from_x <= req_i.from_x;
                seg_q.from_y <= req_i.from_y;
                seg_q.c1_x   <= req_i.c1_x;
                seg_q.c1_y   <= req_i.c1_y;
                seg_q.c2_x   <= req_i.c2_x;
                seg_q.c2_y   <= req_i.c2_y;
                seg_q.end_x  <= req_i.end_x;
                seg_q.end_y  <= req_i.end_y;
                state_q      <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RD:   state_q <= S_CHK;
        S_CHK:  state_q <= qual ? S_DIV : S_IDLE;
        S_DIV:  if (div_done) state_q <= S_EVAL;
        S_EVAL: if (eval_done) state_q <= S_LOOK;
        S_LOOK: state_q <= S_LCHK;
        S_LCHK: begin
          want_nx_q <= rd_data;
          last_q    <= !((idx_nx < count_q) && ({1'b0, rd_data} < seg_end_q));
          state_q   <= S_EMIT;
        end
        S_EMIT: begin
          if (pnt_o.ready) begin
            idx_q   <= idx_nx;
            state_q <= last_q ? S_IDLE : S_DIV;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign pnt_o.valid      = (state_q == S_EMIT);
  assign pnt_o.point_x    = px;
  assign pnt_o.point_y    = py;
  assign pnt_o.last_point = last_q;

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && pnt_o.valid)) else $error("request taken during point output");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT) else $error("table count beyond depth");
  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pnt_o.valid |-> idx_q < count_q) else $error("point without table entry");
  a_div_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("divider finished out of sequence");

endmodule
